// ===== src/fcfs_schedule_metrics_assert.svh =====
`ifndef FCFS_SCHEDULE_METRICS_ASSERT_SVH
`define FCFS_SCHEDULE_METRICS_ASSERT_SVH

// Both macros expect clk and rst_n in the scope where they are used.

`define FCFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define FCFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/fcfs_pkg.sv =====
package fcfs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_PROCS);
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int COMP_W = TIME_BITS + $clog2(MAX_PROCS + 1);

    localparam int FLD_TIME_W = 16;
    localparam int ID_W       = 5;
    localparam int WAIT_W     = 20;
    localparam int TAT_W      = 20;
    localparam int CMPL_W     = 21;
    localparam int SUM_W      = 24;

    localparam int IN_W      = 2 * FLD_TIME_W;
    localparam int OUT_FLD_W = ID_W + 2 * FLD_TIME_W + WAIT_W + TAT_W + CMPL_W + 2 * SUM_W;
    localparam int OUT_W     = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_W - OUT_FLD_W;

    typedef struct packed {
        logic [FLD_TIME_W-1:0] burst;
        logic [FLD_TIME_W-1:0] arrival;
    } in_data_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0]  pad;
        logic [SUM_W-1:0]      turnaround_sum;
        logic [SUM_W-1:0]      waiting_sum;
        logic [CMPL_W-1:0]     completion;
        logic [TAT_W-1:0]      turnaround;
        logic [WAIT_W-1:0]     waiting;
        logic [FLD_TIME_W-1:0] burst_out;
        logic [FLD_TIME_W-1:0] arrival_out;
        logic [ID_W-1:0]       process_id;
    } out_data_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] arrival;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   first;
        logic   last;
        logic   ovf;
        entry_t entry;
    } emit_t;

endpackage

// ===== src/fcfs_ram.sv =====
module fcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/fcfs_ctrl.sv =====
module fcfs_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fcfs_pkg::IN_W-1:0]            s_tdata,   // arrival, burst
    input  logic                                 s_tlast,   // final_input
    output logic                                 ram_we,
    output logic [fcfs_pkg::IDX_W-1:0]           ram_waddr,
    output fcfs_pkg::entry_t                     ram_wdata,
    output logic                                 ram_re,
    output logic [fcfs_pkg::IDX_W-1:0]           ram_raddr,
    input  fcfs_pkg::entry_t                     ram_rdata,
    output fcfs_pkg::emit_t                      emit,
    input  logic                                 calc_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET_I,
        ST_SCAN,
        ST_WB,
        ST_EMIT_RD,
        ST_EMIT_DATA
    } state_t;

    state_t                       state_reg, state_next;
    logic [fcfs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fcfs_pkg::CNT_W-1:0]   n_reg, n_next;
    logic [fcfs_pkg::IDX_W-1:0]   i_reg, i_next;
    logic [fcfs_pkg::IDX_W-1:0]   j_reg, j_next;
    logic                         drop_reg, drop_next;
    fcfs_pkg::entry_t             cur_reg, cur_next;

    always_comb
    begin
        fcfs_pkg::in_data_t          din;
        fcfs_pkg::entry_t            in_entry;
        logic [fcfs_pkg::CNT_W-1:0]  n_cand;
        logic                        last;

        din              = s_tdata;
        in_entry.arrival = fcfs_pkg::TIME_BITS'(din.arrival);
        in_entry.burst   = fcfs_pkg::TIME_BITS'(din.burst);
        in_entry.id      = fcfs_pkg::ID_W'(cnt_reg + fcfs_pkg::CNT_W'(1));
        n_cand           = cnt_reg;
        last             = (fcfs_pkg::CNT_W'(i_reg) + fcfs_pkg::CNT_W'(1)) == n_reg;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        drop_next  = drop_reg;
        cur_next   = cur_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = cur_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        emit       = '0;
        s_tready   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (cnt_reg < fcfs_pkg::CNT_W'(fcfs_pkg::MAX_PROCS))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[fcfs_pkg::IDX_W-1:0];
                        ram_wdata = in_entry;
                        n_cand    = cnt_reg + fcfs_pkg::CNT_W'(1);
                        cnt_next  = n_cand;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next = n_cand;
                        i_next = '0;
                        if (n_cand == fcfs_pkg::CNT_W'(1))
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_GET_I;
                        end
                    end
                end
            end
            ST_GET_I:
            begin
                cur_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = i_reg + fcfs_pkg::IDX_W'(1);
                j_next     = i_reg + fcfs_pkg::IDX_W'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (ram_rdata.arrival < cur_reg.arrival)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                if ((fcfs_pkg::CNT_W'(j_reg) + fcfs_pkg::CNT_W'(1)) == n_reg)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_reg + fcfs_pkg::IDX_W'(1);
                    j_next    = j_reg + fcfs_pkg::IDX_W'(1);
                end
            end
            ST_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = cur_reg;
                if ((fcfs_pkg::CNT_W'(i_reg) + fcfs_pkg::CNT_W'(2)) < n_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg + fcfs_pkg::IDX_W'(1);
                    i_next     = i_reg + fcfs_pkg::IDX_W'(1);
                    state_next = ST_GET_I;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = i_reg;
                state_next = ST_EMIT_DATA;
            end
            ST_EMIT_DATA:
            begin
                emit.valid = 1'b1;
                emit.first = (i_reg == '0);
                emit.last  = last;
                emit.ovf   = drop_reg;
                emit.entry = ram_rdata;
                if (calc_ready)
                begin
                    if (last)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + fcfs_pkg::IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            drop_reg  <= 1'b0;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            drop_reg  <= drop_next;
            cur_reg   <= cur_next;
        end
    end

endmodule

// ===== src/fcfs_calc.sv =====
module fcfs_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcfs_pkg::emit_t               emit,
    output logic                          ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fcfs_pkg::OUT_W-1:0]    m_tdata,   // process_id, arrival_out, burst_out,
                                                     // waiting, turnaround, completion,
                                                     // waiting_sum, turnaround_sum
    output logic                          m_tlast,   // final_result
    output logic                          m_tuser    // overflowed
);

    logic                            a_valid_reg;
    logic                            a_first_reg;
    logic                            a_last_reg;
    logic                            a_ovf_reg;
    logic [fcfs_pkg::ID_W-1:0]       a_id_reg;
    logic [fcfs_pkg::TIME_BITS-1:0]  a_arr_reg;
    logic [fcfs_pkg::TIME_BITS-1:0]  a_bur_reg;
    logic [fcfs_pkg::COMP_W-1:0]     a_comp_reg;
    logic [fcfs_pkg::COMP_W-1:0]     a_wait_reg;
    logic [fcfs_pkg::COMP_W-1:0]     prev_reg;

    logic                            m_valid_reg;
    fcfs_pkg::out_data_t             data_reg, data_next;
    logic                            last_reg;
    logic                            ovf_reg;
    logic [fcfs_pkg::SUM_W-1:0]      wsum_reg, wsum_next;
    logic [fcfs_pkg::SUM_W-1:0]      tsum_reg, tsum_next;

    logic                            a_move;
    logic                            a_load;
    logic [fcfs_pkg::COMP_W-1:0]     prev_eff;
    logic [fcfs_pkg::COMP_W-1:0]     arr_ext;
    logic [fcfs_pkg::COMP_W-1:0]     start_time;
    logic [fcfs_pkg::COMP_W-1:0]     comp_now;
    logic [fcfs_pkg::COMP_W-1:0]     wait_now;
    logic [fcfs_pkg::COMP_W-1:0]     tat;

    assign a_move = a_valid_reg && (!m_valid_reg || m_tready);
    assign ready  = !a_valid_reg || a_move;
    assign a_load = emit.valid && ready;

    // The schedule starts at tick zero on the first entry of a run.
    assign prev_eff   = emit.first ? '0 : prev_reg;
    assign arr_ext    = fcfs_pkg::COMP_W'(emit.entry.arrival);
    assign start_time = (arr_ext > prev_eff) ? arr_ext : prev_eff;
    assign comp_now   = start_time + fcfs_pkg::COMP_W'(emit.entry.burst);
    assign wait_now   = (prev_eff > arr_ext) ? (prev_eff - arr_ext) : '0;

    always_comb
    begin
        tat       = a_wait_reg + fcfs_pkg::COMP_W'(a_bur_reg);
        wsum_next = (a_first_reg ? '0 : wsum_reg) + fcfs_pkg::SUM_W'(a_wait_reg);
        tsum_next = (a_first_reg ? '0 : tsum_reg) + fcfs_pkg::SUM_W'(tat);

        data_next                = '0;
        data_next.process_id     = a_id_reg;
        data_next.arrival_out    = fcfs_pkg::FLD_TIME_W'(a_arr_reg);
        data_next.burst_out      = fcfs_pkg::FLD_TIME_W'(a_bur_reg);
        data_next.waiting        = fcfs_pkg::WAIT_W'(a_wait_reg);
        data_next.turnaround     = fcfs_pkg::TAT_W'(tat);
        data_next.completion     = fcfs_pkg::CMPL_W'(a_comp_reg);
        data_next.waiting_sum    = a_last_reg ? wsum_next : '0;
        data_next.turnaround_sum = a_last_reg ? tsum_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_first_reg <= emit.first;
            a_last_reg  <= emit.last;
            a_ovf_reg   <= emit.ovf;
            a_id_reg    <= emit.entry.id;
            a_arr_reg   <= emit.entry.arrival;
            a_bur_reg   <= emit.entry.burst;
            a_comp_reg  <= comp_now;
            a_wait_reg  <= wait_now;
            prev_reg    <= comp_now;
        end
        if (a_move)
        begin
            data_reg <= data_next;
            last_reg <= a_last_reg;
            ovf_reg  <= a_ovf_reg;
            wsum_reg <= wsum_next;
            tsum_reg <= tsum_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

endmodule

// ===== src/fcfs_schedule_metrics.sv =====
// Channel   Beat contents (tdata from bit 0 up)                               Side bits
// s_*       arrival[15:0], burst[31:16]                                       tlast = final_input
// m_*       process_id, arrival_out, burst_out, waiting, turnaround,          tlast = final_result
//           completion, waiting_sum, turnaround_sum (146 bits, 152 wide)      tuser = overflowed
//
// Loading accepts one beat per cycle while s_tready is high; the entry store has one read and one write port.
// After the final beat, an exchange sort orders the held entries by arrival time,
// reading them through the single read port of the entry store.
// Emission then reads each result in ST_EMIT_RD and hands it on in ST_EMIT_DATA, holding while m_tready is low.
// rst_n clears control state asynchronously; no store clearing is needed after reset.
// s_tready is low from the final beat until the metrics stage takes the last result.
`include "fcfs_schedule_metrics_assert.svh"

module fcfs_schedule_metrics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fcfs_pkg::IN_W-1:0]     s_tdata,   // arrival, burst
    input  logic                          s_tlast,   // final_input
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fcfs_pkg::OUT_W-1:0]    m_tdata,   // process_id, arrival_out, burst_out,
                                                     // waiting, turnaround, completion,
                                                     // waiting_sum, turnaround_sum
    output logic                          m_tlast,   // final_result
    output logic                          m_tuser    // overflowed
);

    logic                            ram_we;
    logic [fcfs_pkg::IDX_W-1:0]      ram_waddr;
    fcfs_pkg::entry_t                ram_wdata;
    logic                            ram_re;
    logic [fcfs_pkg::IDX_W-1:0]      ram_raddr;
    fcfs_pkg::entry_t                ram_rdata;
    fcfs_pkg::emit_t                 emit;
    logic                            calc_ready;
    fcfs_pkg::out_data_t             mon;

    fcfs_ram #(
        .WIDTH ($bits(fcfs_pkg::entry_t)),
        .DEPTH (fcfs_pkg::MAX_PROCS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fcfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .emit       (emit),
        .calc_ready (calc_ready)
    );

    fcfs_calc u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .ready    (calc_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign mon = m_tdata;

    `FCFS_ASSERT_NOW(a_busy_while_emitting, emit.valid, !s_tready)
    `FCFS_ASSERT_NEXT(a_final_beat_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready)
    `FCFS_ASSERT_NOW(a_turnaround_split, m_tvalid,
        mon.turnaround == (mon.waiting + mon.burst_out))

endmodule

// ===== verif/tb_fcfs_schedule_metrics.sv =====
`timescale 1ns / 1ps

module tb_fcfs_schedule_metrics;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 250;
    localparam int HOLD_CYCLES  = 500;
    localparam int MAX_REPORTS  = 10;
    localparam int LIMIT_CYCLES = 400000;

    localparam int ARR_RANDOM = 0;
    localparam int ARR_TIES   = 1;
    localparam int ARR_RISING = 2;
    localparam int ARR_HIGH   = 3;

    localparam int BUR_RANDOM = 0;
    localparam int BUR_SHORT  = 1;
    localparam int BUR_LONG   = 2;

    typedef struct {
        fcfs_pkg::out_data_t data;
        logic                is_last;
        logic                ovf;
    } metrics_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [fcfs_pkg::IN_W-1:0]      s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [fcfs_pkg::OUT_W-1:0]     m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    logic [fcfs_pkg::FLD_TIME_W-1:0] held_arrival [fcfs_pkg::MAX_PROCS];
    logic [fcfs_pkg::FLD_TIME_W-1:0] held_burst   [fcfs_pkg::MAX_PROCS];
    int                              held_count;
    logic                            dropped;

    metrics_t pending_metrics [$];

    event hold_start;
    logic hold_active;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches   = 0;
    int items_loaded;
    int runs_done;
    int overflow_runs;
    int results_seen = 0;

    fcfs_schedule_metrics i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stores one process and, on the last one of a run, works out the FCFS metrics.
    task automatic load_process(input logic [fcfs_pkg::FLD_TIME_W-1:0] arr,
                                input logic [fcfs_pkg::FLD_TIME_W-1:0] bur,
                                input logic is_last);
        logic [fcfs_pkg::FLD_TIME_W-1:0] arr_s [fcfs_pkg::MAX_PROCS];
        logic [fcfs_pkg::FLD_TIME_W-1:0] bur_s [fcfs_pkg::MAX_PROCS];
        logic [fcfs_pkg::ID_W-1:0]       id_s  [fcfs_pkg::MAX_PROCS];
        logic [fcfs_pkg::FLD_TIME_W-1:0] t_arr;
        logic [fcfs_pkg::FLD_TIME_W-1:0] t_bur;
        logic [fcfs_pkg::ID_W-1:0]       t_id;
        int unsigned                     prev_cmpl;
        int unsigned                     cmpl;
        int unsigned                     tat;
        int unsigned                     wt;
        int unsigned                     wsum;
        int unsigned                     tsum;
        metrics_t                        m;

        items_loaded++;
        if (held_count < fcfs_pkg::MAX_PROCS)
        begin
            held_arrival[held_count] = arr;
            held_burst[held_count]   = bur;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!is_last)
        begin
            return;
        end

        for (int i = 0; i < held_count; i++)
        begin
            arr_s[i] = held_arrival[i];
            bur_s[i] = held_burst[i];
            id_s[i]  = fcfs_pkg::ID_W'(i + 1);
        end
        for (int i = 0; i + 1 < held_count; i++)
        begin
            for (int j = i + 1; j < held_count; j++)
            begin
                if (arr_s[i] > arr_s[j])
                begin
                    t_arr = arr_s[i];
                    t_bur = bur_s[i];
                    t_id  = id_s[i];
                    arr_s[i] = arr_s[j];
                    bur_s[i] = bur_s[j];
                    id_s[i]  = id_s[j];
                    arr_s[j] = t_arr;
                    bur_s[j] = t_bur;
                    id_s[j]  = t_id;
                end
            end
        end

        prev_cmpl = 0;
        wsum      = 0;
        tsum      = 0;
        for (int i = 0; i < held_count; i++)
        begin
            cmpl = ((arr_s[i] > prev_cmpl) ? arr_s[i] : prev_cmpl) + bur_s[i];
            tat  = cmpl - arr_s[i];
            wt   = tat - bur_s[i];
            prev_cmpl = cmpl;
            wsum += wt;
            tsum += tat;
            m.data             = '0;
            m.data.process_id  = id_s[i];
            m.data.arrival_out = arr_s[i];
            m.data.burst_out   = bur_s[i];
            m.data.waiting     = fcfs_pkg::WAIT_W'(wt);
            m.data.turnaround  = fcfs_pkg::TAT_W'(tat);
            m.data.completion  = fcfs_pkg::CMPL_W'(cmpl);
            m.is_last          = (i + 1 == held_count);
            m.data.waiting_sum    = m.is_last ? fcfs_pkg::SUM_W'(wsum) : '0;
            m.data.turnaround_sum = m.is_last ? fcfs_pkg::SUM_W'(tsum) : '0;
            m.ovf              = dropped;
            pending_metrics.push_back(m);
        end

        runs_done++;
        if (dropped)
        begin
            overflow_runs++;
        end
        held_count = 0;
        dropped    = 1'b0;
    endtask

    // A valid that stays high for the next beat is not lowered in between.
    task automatic send_process(input logic [fcfs_pkg::FLD_TIME_W-1:0] arr,
                                input logic [fcfs_pkg::FLD_TIME_W-1:0] bur,
                                input logic is_last);
        fcfs_pkg::in_data_t beat;

        beat.arrival = arr;
        beat.burst   = bur;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tlast  <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        load_process(arr, bur, is_last);
    endtask

    task automatic send_run(input int len, input int arr_mode, input int bur_mode);
        logic [fcfs_pkg::FLD_TIME_W-1:0] arr;
        logic [fcfs_pkg::FLD_TIME_W-1:0] bur;
        int                              base;

        base = $urandom_range(0, 1000);
        for (int k = 0; k < len; k++)
        begin
            unique case (arr_mode)
                ARR_TIES:   arr = fcfs_pkg::FLD_TIME_W'($urandom_range(0, 7));
                ARR_RISING:
                begin
                    base = base + $urandom_range(0, 300);
                    arr  = (base > 65535) ? 16'hFFFF : fcfs_pkg::FLD_TIME_W'(base);
                end
                ARR_HIGH:   arr = fcfs_pkg::FLD_TIME_W'($urandom_range(65528, 65535));
                default:    arr = fcfs_pkg::FLD_TIME_W'($urandom_range(0, 65535));
            endcase
            unique case (bur_mode)
                BUR_SHORT: bur = fcfs_pkg::FLD_TIME_W'($urandom_range(0, 15));
                BUR_LONG:  bur = fcfs_pkg::FLD_TIME_W'($urandom_range(65500, 65535));
                default:   bur = fcfs_pkg::FLD_TIME_W'($urandom_range(0, 65535));
            endcase
            send_process(arr, bur, k == len - 1);
        end
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        send_process(16'hFFFF, 16'hFFFF, 1'b1);

        send_process(16'd5, 16'd10, 1'b0);
        send_process(16'd5, 16'd0, 1'b0);
        send_process(16'd3, 16'd7, 1'b1);

        send_process(16'd300, 16'd0, 1'b0);
        send_process(16'd200, 16'd0, 1'b0);
        send_process(16'd100, 16'd0, 1'b0);
        send_process(16'd0, 16'd0, 1'b1);

        // Sixteen held entries, then a last beat that is dropped but still starts the run.
        for (int k = 0; k < fcfs_pkg::MAX_PROCS; k++)
        begin
            send_process((k % 3 == 0) ? 16'hFFFF : 16'h0000, 16'hFFFF, 1'b0);
        end
        send_process(16'h1234, 16'hABCD, 1'b1);
    endtask

    task automatic test_random_runs(input int item_budget);
        int start;
        int pick;
        int len;

        start = items_loaded;
        while (items_loaded - start < item_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = fcfs_pkg::MAX_PROCS;
            else if (pick < 20)
                len = $urandom_range(fcfs_pkg::MAX_PROCS + 1, fcfs_pkg::MAX_PROCS + 4);
            else
                len = $urandom_range(1, fcfs_pkg::MAX_PROCS);
            send_run(len, $urandom_range(ARR_RANDOM, ARR_HIGH),
                     $urandom_range(BUR_RANDOM, BUR_LONG));
        end
    endtask

    task automatic test_backpressure();
        set_idle(0, 0);
        send_run(fcfs_pkg::MAX_PROCS, ARR_RANDOM, BUR_RANDOM);
        -> hold_start;
        send_run(12, ARR_TIES, BUR_SHORT);
        send_run(12, ARR_RISING, BUR_RANDOM);
    endtask

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_start);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_active)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $display("mismatch at %0t on %s: expected %0d, got %0d", $realtime, name,
                         exp_v, act_v);
            end
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_beat
        metrics_t            want;
        fcfs_pkg::out_data_t got;

        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (pending_metrics.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                begin
                    $display("unexpected result beat at %0t: id %0d", $realtime,
                             got.process_id);
                end
                mismatches++;
            end
            else
            begin
                want = pending_metrics.pop_front();
                check_field("process_id", want.data.process_id, got.process_id);
                check_field("arrival_out", want.data.arrival_out, got.arrival_out);
                check_field("burst_out", want.data.burst_out, got.burst_out);
                check_field("waiting", want.data.waiting, got.waiting);
                check_field("turnaround", want.data.turnaround, got.turnaround);
                check_field("completion", want.data.completion, got.completion);
                check_field("waiting_sum", want.data.waiting_sum, got.waiting_sum);
                check_field("turnaround_sum", want.data.turnaround_sum, got.turnaround_sum);
                check_field("final_result", want.is_last, m_tlast);
                check_field("overflowed", want.ovf, m_tuser);
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        held_count     = 0;
        dropped        = 1'b0;
        items_loaded   = 0;
        runs_done      = 0;
        overflow_runs  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_idle(0, 0);
        test_random_runs(100);
        set_idle(55, 0);
        test_random_runs(100);
        set_idle(0, 55);
        test_random_runs(100);
        set_idle(23, 23);
        test_random_runs(100);
        test_backpressure();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_metrics.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats in %0d runs, %0d of them over capacity.",
                 items_loaded, runs_done, overflow_runs);
        $display("Checked %0d result beats under four idle mixes and one long output stall.",
                 results_seen);
        if (mismatches == 0 && pending_metrics.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fcfs_pkg.sv
src/fcfs_ram.sv
src/fcfs_ctrl.sv
src/fcfs_calc.sv
src/fcfs_schedule_metrics.sv
verif/tb_fcfs_schedule_metrics.sv
